// ===== hw/rtl/pcbq_pkg.sv =====
// Shared constants for the PCB pool priority queue: field widths and request codes.
`timescale 1ns / 1ps
`default_nettype none

package pcbq_pkg;

    localparam int REQ_W      = 3;
    localparam int QSEL_W     = 3;
    localparam int SLOT_W     = 5;
    localparam int PRIO_W     = 8;
    localparam int CFG_W      = 8;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    localparam logic [REQ_W-1:0] REQ_ALLOC    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RM_HEAD  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RM_GIVEN = 3'd4;
    localparam logic [REQ_W-1:0] REQ_HEAD     = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/pcbq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pcbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pcb_pool_priority_queue_core.sv =====
// PCB pool with free list and priority queues over one shared link RAM.
// Per request: start and head read, then a walk of up to NUM_SLOTS entries for insert into a
//   non-empty queue or remove given, then the alloc, free, remove-head, query or insert state and
//   a link write-back where needed, then the response; a null result skips to the response.
// Requests are taken one at a time, only while idle; an untaken result holds input.
// Reset: async, active low; then the link and priority RAMs are initialized before the first beat.
`timescale 1ns / 1ps
`default_nettype none

module pcb_pool_priority_queue_core #(
    parameter int NUM_SLOTS  = 32,
    parameter int NUM_QUEUES = 8,
    parameter int PRIO_BITS  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] slot_index, [12:5] priority_req, [15:13] zero
    input  logic [pcbq_pkg::IN_DATA_W-1:0]    s_tdata,
    // [2:0] req_type, [5:3] queue_sel
    input  logic [pcbq_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] result_slot, [12:5] result_priority, [15:13] zero
    output logic [pcbq_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] found
    output logic [pcbq_pkg::OUT_USER_W-1:0]   m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcbq_pkg::CFG_W-1:0]        cfg_data
);

    import pcbq_pkg::*;

    localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
    localparam int NUM_ENT = NUM_SLOTS + NUM_QUEUES + 1;
    localparam int AW      = $clog2(NUM_ENT);
    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(NUM_SLOTS);
    localparam logic [AW-1:0]     FREE_ADDR = AW'(NUM_SLOTS + NUM_QUEUES);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(NUM_ENT - 1);
    localparam logic [CNT_W-1:0]  WALK_LAST = CNT_W'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_START,
        ST_HEAD,
        ST_WALK,
        ST_ALLOC,
        ST_FREE,
        ST_RMH,
        ST_QRY,
        ST_INS,
        ST_WB,
        ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [QSEL_W-1:0]       q_reg, q_next;
    logic [SLOT_W-1:0]       s_reg, s_next;
    logic [PRIO_BITS-1:0]    p_reg, p_next;
    logic [LINK_W-1:0]       cur_reg, cur_next;
    logic [AW-1:0]           prev_reg, prev_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]           wb_addr_reg, wb_addr_next;
    logic [LINK_W-1:0]       wb_data_reg, wb_data_next;
    logic [LINK_W-1:0]       res_slot_reg, res_slot_next;
    logic [PRIO_BITS-1:0]    res_prio_reg, res_prio_next;
    logic                    res_found_reg, res_found_next;
    logic [AW-1:0]           init_reg, init_next;
    logic [CFG_W-1:0]        mask_reg, mask_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                    lk_we;
    logic [AW-1:0]           lk_waddr, lk_raddr;
    logic [LINK_W-1:0]       lk_wdata, lk_rdata;
    logic                    pr_we;
    logic [IDX_W-1:0]        pr_waddr, pr_raddr;
    logic [PRIO_BITS-1:0]    pr_wdata, pr_rdata;

    logic                    s_ok;
    logic                    q_ok;
    logic                    req_ok;
    logic [AW-1:0]           head_addr;
    logic [AW-1:0]           list_addr;
    logic [LINK_W-1:0]       s_link;
    logic [LINK_W-1:0]       rd_link;
    logic [PRIO_BITS-1:0]    masked_prio;
    logic                    walk_last;

    function automatic logic [LINK_W-1:0] clamp_link(input logic [LINK_W-1:0] x);
        return (32'(x) >= NUM_SLOTS) ? NIL : x;
    endfunction

    pcbq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_ENT)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    pcbq_ram #(
        .WIDTH (PRIO_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_prio_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    // queue heads and the free head live in the link RAM above the slot entries
    assign s_ok        = 32'(s_reg) < NUM_SLOTS;
    assign q_ok        = 32'(q_reg) < NUM_QUEUES;
    assign head_addr   = AW'(32'(NUM_SLOTS) + 32'(q_reg));
    assign s_link      = LINK_W'(s_reg);
    assign rd_link     = clamp_link(lk_rdata);
    assign masked_prio = pr_rdata & PRIO_BITS'(mask_reg);
    assign walk_last   = (cnt_reg == WALK_LAST);

    always_comb
    begin
        unique case (req_reg)
            REQ_ALLOC:
            begin
                req_ok    = 1'b1;
                list_addr = FREE_ADDR;
            end
            REQ_FREE:
            begin
                req_ok    = s_ok;
                list_addr = FREE_ADDR;
            end
            REQ_INSERT, REQ_RM_GIVEN:
            begin
                req_ok    = s_ok && q_ok;
                list_addr = head_addr;
            end
            REQ_RM_HEAD, REQ_HEAD:
            begin
                req_ok    = q_ok;
                list_addr = head_addr;
            end
            default:
            begin
                req_ok    = 1'b0;
                list_addr = FREE_ADDR;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        q_next         = q_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        wb_addr_next   = wb_addr_reg;
        wb_data_next   = wb_data_reg;
        res_slot_next  = res_slot_reg;
        res_prio_next  = res_prio_reg;
        res_found_next = res_found_reg;
        init_next      = init_reg;
        mask_next      = cfg_valid ? cfg_data : mask_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        lk_we    = 1'b0;
        lk_waddr = wb_addr_reg;
        lk_wdata = wb_data_reg;
        lk_raddr = AW'(cur_reg);
        pr_we    = 1'b0;
        pr_waddr = IDX_W'(s_reg);
        pr_wdata = '0;
        pr_raddr = IDX_W'(cur_reg);

        s_tready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_INIT:
            begin
                lk_we    = 1'b1;
                lk_waddr = init_reg;
                if (32'(init_reg) < NUM_SLOTS)
                begin
                    lk_wdata = LINK_W'(32'(init_reg) + 1);
                end
                else if (init_reg < FREE_ADDR)
                begin
                    lk_wdata = NIL;
                end
                else
                begin
                    lk_wdata = '0;
                end
                pr_we    = 32'(init_reg) < NUM_SLOTS;
                pr_waddr = IDX_W'(init_reg);
                if (init_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_next = init_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next   = s_tuser[2:0];
                    q_next     = s_tuser[5:3];
                    s_next     = s_tdata[4:0];
                    p_next     = PRIO_BITS'(s_tdata[12:5]);
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                res_found_next = 1'b0;
                lk_raddr       = list_addr;
                prev_next      = list_addr;
                if (req_ok && req_reg == REQ_INSERT)
                begin
                    pr_we    = 1'b1;
                    pr_waddr = IDX_W'(s_reg);
                    pr_wdata = p_reg;
                end
                state_next = req_ok ? ST_HEAD : ST_RESP;
            end

            ST_HEAD:
            begin
                cur_next = rd_link;
                cnt_next = '0;
                lk_raddr = AW'(rd_link);
                pr_raddr = IDX_W'(rd_link);
                unique case (req_reg)
                    REQ_ALLOC:
                    begin
                        state_next = (rd_link == NIL) ? ST_RESP : ST_ALLOC;
                    end
                    REQ_FREE:
                    begin
                        lk_we      = 1'b1;
                        lk_waddr   = AW'(s_reg);
                        lk_wdata   = rd_link;
                        pr_raddr   = IDX_W'(s_reg);
                        state_next = ST_FREE;
                    end
                    REQ_INSERT:
                    begin
                        state_next = (rd_link == NIL) ? ST_INS : ST_WALK;
                    end
                    REQ_RM_HEAD:
                    begin
                        state_next = (rd_link == NIL) ? ST_RESP : ST_RMH;
                    end
                    REQ_RM_GIVEN:
                    begin
                        state_next = (rd_link == NIL) ? ST_RESP : ST_WALK;
                    end
                    REQ_HEAD:
                    begin
                        state_next = (rd_link == NIL) ? ST_RESP : ST_QRY;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_WALK:
            begin
                if (req_reg == REQ_RM_GIVEN)
                begin
                    if (cur_reg == s_link)
                    begin
                        lk_we          = 1'b1;
                        lk_waddr       = prev_reg;
                        lk_wdata       = rd_link;
                        wb_addr_next   = AW'(s_reg);
                        wb_data_next   = NIL;
                        res_slot_next  = s_link;
                        res_prio_next  = pr_rdata;
                        res_found_next = 1'b1;
                        state_next     = ST_WB;
                    end
                    else
                    begin
                        prev_next = AW'(cur_reg);
                        cur_next  = rd_link;
                        cnt_next  = cnt_reg + 1'b1;
                        lk_raddr  = AW'(rd_link);
                        pr_raddr  = IDX_W'(rd_link);
                        if (walk_last || rd_link == NIL)
                        begin
                            state_next = ST_RESP;
                        end
                    end
                end
                else
                begin
                    if (pr_rdata <= p_reg)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        prev_next = AW'(cur_reg);
                        cur_next  = rd_link;
                        cnt_next  = cnt_reg + 1'b1;
                        lk_raddr  = AW'(rd_link);
                        pr_raddr  = IDX_W'(rd_link);
                        if (walk_last || rd_link == NIL)
                        begin
                            state_next = ST_INS;
                        end
                    end
                end
            end

            ST_ALLOC:
            begin
                lk_we          = 1'b1;
                lk_waddr       = FREE_ADDR;
                lk_wdata       = rd_link;
                pr_we          = 1'b1;
                pr_waddr       = IDX_W'(cur_reg);
                pr_wdata       = '0;
                wb_addr_next   = AW'(cur_reg);
                wb_data_next   = NIL;
                res_slot_next  = cur_reg;
                res_prio_next  = '0;
                res_found_next = 1'b1;
                state_next     = ST_WB;
            end

            ST_FREE:
            begin
                lk_we          = 1'b1;
                lk_waddr       = FREE_ADDR;
                lk_wdata       = s_link;
                res_slot_next  = s_link;
                res_prio_next  = pr_rdata;
                res_found_next = 1'b1;
                state_next     = ST_RESP;
            end

            ST_RMH:
            begin
                lk_we          = 1'b1;
                lk_waddr       = prev_reg;
                lk_wdata       = rd_link;
                pr_we          = 1'b1;
                pr_waddr       = IDX_W'(cur_reg);
                pr_wdata       = masked_prio;
                wb_addr_next   = AW'(cur_reg);
                wb_data_next   = NIL;
                res_slot_next  = cur_reg;
                res_prio_next  = masked_prio;
                res_found_next = 1'b1;
                state_next     = ST_WB;
            end

            ST_QRY:
            begin
                res_slot_next  = cur_reg;
                res_prio_next  = pr_rdata;
                res_found_next = 1'b1;
                state_next     = ST_RESP;
            end

            ST_INS:
            begin
                lk_we          = 1'b1;
                lk_waddr       = AW'(s_reg);
                lk_wdata       = cur_reg;
                wb_addr_next   = prev_reg;
                wb_data_next   = s_link;
                res_slot_next  = s_link;
                res_prio_next  = p_reg;
                res_found_next = 1'b1;
                state_next     = ST_WB;
            end

            ST_WB:
            begin
                lk_we      = 1'b1;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = OUT_USER_W'(res_found_reg);
                    m_tdata_next  = res_found_reg
                        ? OUT_DATA_W'({PRIO_W'(res_prio_reg), SLOT_W'(res_slot_reg)})
                        : '0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            req_reg       <= '0;
            q_reg         <= '0;
            s_reg         <= '0;
            p_reg         <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            wb_addr_reg   <= '0;
            wb_data_reg   <= '0;
            res_slot_reg  <= '0;
            res_prio_reg  <= '0;
            res_found_reg <= 1'b0;
            init_reg      <= '0;
            mask_reg      <= 8'hFF;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            q_reg         <= q_next;
            s_reg         <= s_next;
            p_reg         <= p_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            wb_addr_reg   <= wb_addr_next;
            wb_data_reg   <= wb_data_next;
            res_slot_reg  <= res_slot_next;
            res_prio_reg  <= res_prio_next;
            res_found_reg <= res_found_next;
            init_reg      <= init_next;
            mask_reg      <= mask_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== verif/pcb_pool_priority_queue_core_tb.sv =====
// Testbench for pcb_pool_priority_queue_core: stream drivers, slot-pool predictor and scoreboard.
`timescale 1ns / 1ps

module pcb_pool_priority_queue_core_tb;
    import pcbq_pkg::*;

    localparam int NUM_SLOTS   = 32;
    localparam int NUM_QUEUES  = 8;
    localparam int PRIO_BITS   = 8;
    localparam int HOLD_CYCLES = 300;
    localparam logic [SLOT_W:0]  LINK_NIL  = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic [PRIO_W-1:0] prio;
    } pcb_result_t;

    typedef enum logic [1:0] {SLOT_FREE, SLOT_HELD, SLOT_QUEUED} slot_use_t;

    class pcb_pool_scoreboard;
        logic [SLOT_W:0]   link_mem [NUM_SLOTS];
        logic [PRIO_W-1:0] prio_mem [NUM_SLOTS];
        logic [SLOT_W:0]   qhead    [NUM_QUEUES];
        logic [SLOT_W:0]   free_top;
        logic [PRIO_W-1:0] mask;
        pcb_result_t       awaited [$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                link_mem[i] = (SLOT_W + 1)'(i + 1);
                prio_mem[i] = '0;
            end
            foreach (qhead[i])
                qhead[i] = LINK_NIL;
            free_top   = '0;
            mask       = '1;
            mismatches = 0;
            checked    = 0;
        endfunction

        function logic [SLOT_W:0] link_of(logic [SLOT_W:0] s);
            if (s >= LINK_NIL)
                return LINK_NIL;
            return (link_mem[s[SLOT_W-1:0]] >= LINK_NIL) ? LINK_NIL : link_mem[s[SLOT_W-1:0]];
        endfunction

        function pcb_result_t hit(logic [SLOT_W-1:0] s, logic [PRIO_W-1:0] p);
            return '{slot: s, found: 1'b1, prio: p};
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function pcb_result_t note_request(logic [REQ_W-1:0] req, logic [QSEL_W-1:0] q,
                                           logic [SLOT_W-1:0] s, logic [PRIO_W-1:0] p);
            pcb_result_t     r;
            logic [SLOT_W:0] h;
            logic [SLOT_W:0] prev;
            logic [SLOT_W:0] cur;
            bit              walking;
            r    = '0;
            h    = qhead[q];
            prev = LINK_NIL;
            cur  = h;
            case (req)
                REQ_ALLOC:
                    if (free_top != LINK_NIL)
                    begin
                        h = free_top;
                        free_top = link_of(h);
                        link_mem[h[SLOT_W-1:0]] = LINK_NIL;
                        prio_mem[h[SLOT_W-1:0]] = '0;
                        r = hit(h[SLOT_W-1:0], '0);
                    end
                REQ_FREE:
                begin
                    link_mem[s] = free_top;
                    free_top = {1'b0, s};
                    r = hit(s, prio_mem[s]);
                end
                REQ_INSERT:
                begin
                    prio_mem[s] = p;
                    for (int n = 0; n < NUM_SLOTS; n++)
                    begin
                        if (cur == LINK_NIL || prio_mem[cur[SLOT_W-1:0]] <= p)
                            break;
                        prev = cur;
                        cur = link_of(cur);
                    end
                    link_mem[s] = cur;
                    if (prev == LINK_NIL)
                        qhead[q] = {1'b0, s};
                    else
                        link_mem[prev[SLOT_W-1:0]] = {1'b0, s};
                    r = hit(s, p);
                end
                REQ_RM_HEAD:
                    if (h != LINK_NIL)
                    begin
                        qhead[q] = link_of(h);
                        link_mem[h[SLOT_W-1:0]] = LINK_NIL;
                        prio_mem[h[SLOT_W-1:0]] = prio_mem[h[SLOT_W-1:0]] & mask;
                        r = hit(h[SLOT_W-1:0], prio_mem[h[SLOT_W-1:0]]);
                    end
                REQ_RM_GIVEN:
                begin
                    walking = 1'b1;
                    for (int n = 0; n < NUM_SLOTS && walking; n++)
                    begin
                        if (cur == LINK_NIL)
                            walking = 1'b0;
                        else if (cur == {1'b0, s})
                        begin
                            if (prev == LINK_NIL)
                                qhead[q] = link_of({1'b0, s});
                            else
                                link_mem[prev[SLOT_W-1:0]] = link_of({1'b0, s});
                            link_mem[s] = LINK_NIL;
                            r = hit(s, prio_mem[s]);
                            walking = 1'b0;
                        end
                        else
                        begin
                            prev = cur;
                            cur = link_of(cur);
                        end
                    end
                end
                REQ_HEAD:
                    if (h != LINK_NIL)
                        r = hit(h[SLOT_W-1:0], prio_mem[h[SLOT_W-1:0]]);
                default:
                    r = '0;
            endcase
            awaited.push_back(r);
            return r;
        endfunction

        function void check_result(pcb_result_t got);
            pcb_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with none expected: slot %0d found %0b prio %0d",
                         $time, got.slot, got.found, got.prio);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
                mismatches++;
            end
            if (got.slot !== want.slot)
            begin
                $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
                mismatches++;
            end
            if (got.prio !== want.prio)
            begin
                $display("%0t: prio expected %0d, got %0d", $time, want.prio, got.prio);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    pcb_pool_scoreboard sb;
    slot_use_t          slot_use   [NUM_SLOTS];
    logic [QSEL_W-1:0]  slot_queue [NUM_SLOTS];
    bit                 tx_idle_en;
    bit                 rx_stall_en;
    bit                 hold_off_req;
    int unsigned        items_sent;
    int unsigned        empty_allocs;
    int unsigned        masks_written;

    pcb_pool_priority_queue_core #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_QUEUES (NUM_QUEUES),
        .PRIO_BITS  (PRIO_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result('{slot: m_tdata[SLOT_W-1:0], found: m_tuser[0],
                              prio: m_tdata[SLOT_W +: PRIO_W]});
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_stall_en && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic void track(logic [REQ_W-1:0] req, logic [QSEL_W-1:0] q,
                                  logic [SLOT_W-1:0] s, pcb_result_t r);
        case (req)
            REQ_ALLOC:
                if (r.found)
                    slot_use[r.slot] = SLOT_HELD;
                else
                    empty_allocs++;
            REQ_FREE:
                slot_use[s] = SLOT_FREE;
            REQ_INSERT:
            begin
                slot_use[s]   = SLOT_QUEUED;
                slot_queue[s] = q;
            end
            REQ_RM_HEAD, REQ_RM_GIVEN:
                if (r.found)
                    slot_use[r.slot] = SLOT_HELD;
            default:
                ;
        endcase
    endfunction

    function automatic int pick_slot(slot_use_t want);
        int cand [$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_use[i] == want)
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return PRIO_W'($urandom_range(0, 3));
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    function automatic logic [QSEL_W-1:0] rand_queue();
        if ($urandom_range(0, 2) == 0)
            return QSEL_W'($urandom);
        return QSEL_W'($urandom_range(0, 1));
    endfunction

    // valid stays high between back-to-back beats unless tx_idle_en adds gaps; wait_drained lowers it
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [QSEL_W-1:0] q,
                            input logic [SLOT_W-1:0] s, input logic [PRIO_W-1:0] p);
        pcb_result_t r;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - PRIO_W - SLOT_W){1'b0}}, p, s};
        s_tuser  <= {q, req};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        r = sb.note_request(req, q, s, p);
        items_sent++;
        track(req, q, s, r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_mask(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.mask = v;
        masks_written++;
    endtask

    // well-formed traffic: slots move free -> held -> queued and back
    task automatic run_orderly(input int count, input bit grow);
        int                roll;
        int                s;
        logic [QSEL_W-1:0] q;
        logic [PRIO_W-1:0] p;
        logic [SLOT_W-1:0] rs;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            q = rand_queue();
            p = rand_prio();
            rs = SLOT_W'($urandom);
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            if (roll < (grow ? 30 : 10))
                send_req(REQ_ALLOC, q, rs, p);
            else if (roll < (grow ? 60 : 35))
            begin
                s = pick_slot(SLOT_HELD);
                if (s < 0)
                    send_req(REQ_ALLOC, q, rs, p);
                else
                    send_req(REQ_INSERT, q, SLOT_W'(s), p);
            end
            else if (roll < (grow ? 68 : 55))
                send_req(REQ_RM_HEAD, q, rs, p);
            else if (roll < (grow ? 76 : 75))
            begin
                s = pick_slot(SLOT_QUEUED);
                if (s >= 0 && $urandom_range(0, 5) != 0)
                    send_req(REQ_RM_GIVEN, slot_queue[s], SLOT_W'(s), p);
                else
                    send_req(REQ_RM_GIVEN, q, rs, p);
            end
            else if (roll < (grow ? 84 : 92))
            begin
                s = pick_slot(SLOT_HELD);
                if (s < 0)
                    send_req(REQ_HEAD, q, rs, p);
                else
                    send_req(REQ_FREE, q, SLOT_W'(s), p);
            end
            else if (roll < 96)
                send_req(REQ_HEAD, q, rs, p);
            else
                send_req($urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7, q, rs, p);
        end
    endtask

    // anything goes: double frees and re-inserts corrupt the lists and bound the walks
    task automatic run_chaos(input int count);
        logic [REQ_W-1:0] req;
        repeat (count)
        begin
            req = REQ_W'($urandom_range(0, 7));
            send_req(req, QSEL_W'($urandom), SLOT_W'($urandom), rand_prio());
        end
    endtask

    initial
    begin
        sb = new();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_use[i]   = SLOT_FREE;
            slot_queue[i] = '0;
        end
        items_sent    = 0;
        empty_allocs  = 0;
        masks_written = 0;
        tx_idle_en    = 1'b0;
        rx_stall_en   = 1'b0;
        hold_off_req  = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_mask(8'hFF);

        send_req(REQ_HEAD, 3'd0, 5'd0, 8'h00);
        send_req(REQ_RM_HEAD, 3'd7, 5'd0, 8'h00);
        send_req(REQ_RM_GIVEN, 3'd3, 5'd31, 8'h00);
        send_req(REQ_RSVD6, 3'd7, 5'd31, 8'hFF);
        send_req(REQ_RSVD7, 3'd0, 5'd0, 8'h00);
        repeat (4)
            send_req(REQ_ALLOC, 3'd0, 5'd0, 8'h00);
        send_req(REQ_INSERT, 3'd0, 5'd0, 8'h00);
        send_req(REQ_INSERT, 3'd0, 5'd1, 8'hFF);
        send_req(REQ_INSERT, 3'd0, 5'd2, 8'h00);    // tie goes ahead of slot 0
        send_req(REQ_INSERT, 3'd0, 5'd3, 8'h80);
        send_req(REQ_HEAD, 3'd0, 5'd0, 8'h00);
        send_req(REQ_RM_GIVEN, 3'd0, 5'd0, 8'h00);  // tail
        send_req(REQ_RM_GIVEN, 3'd0, 5'd3, 8'h00);  // middle
        send_req(REQ_RM_GIVEN, 3'd0, 5'd1, 8'h00);  // head
        send_req(REQ_INSERT, 3'd7, 5'd1, 8'hC3);
        send_req(REQ_RM_HEAD, 3'd0, 5'd0, 8'h00);
        send_req(REQ_FREE, 3'd0, 5'd2, 8'h00);
        send_req(REQ_FREE, 3'd0, 5'd0, 8'h00);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_mask(8'h00);
                1: write_mask(8'hFF);
                2: write_mask(8'hF0);
                3: write_mask(8'h0F);
                default: write_mask(CFG_W'($urandom));
            endcase
            tx_idle_en  = (ph % 3 != 1);
            rx_stall_en = (ph % 3 != 2);
            if (ph == 2)
            begin
                tx_idle_en   = 1'b0;
                hold_off_req = 1'b1;
            end
            run_orderly(200, ph % 2 == 0);
            wait_drained();
        end

        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        write_mask(CFG_W'($urandom));
        run_chaos(300);
        wait_drained();
        repeat (64) @(posedge clk);

        $display("Covered %0d requests, %0d results checked, %0d mask settings.",
                 items_sent, sb.checked, masks_written);
        $display("Alloc hit an empty pool %0d times; %0d field errors.",
                 empty_allocs, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
